// File: rtl/dcv_pkg.sv
`timescale 1ns / 1ps
// dcv_pkg: shared types, codes and helpers of the depthwise convolution block
// no dependencies

package dcv_pkg;

    localparam int DATA_W    = 16;
    localparam int ROW_W     = 9;
    localparam int CFG_COUNT = 7;

    typedef enum logic [1:0] {
        CMD_PIXEL  = 2'd0,
        CMD_WEIGHT = 2'd1,
        CMD_BIAS   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_CHANNELS   = 3'd0,
        CFG_OUT_HEIGHT = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_KER_ROWS   = 3'd3,
        CFG_KER_COLS   = 3'd4,
        CFG_RELU       = 3'd5,
        CFG_FRAC       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [5:0] channel;
        logic [7:0] row;
        logic [7:0] col;
        logic       last;
    } t_meta;

    typedef struct packed {
        logic [2:0] kr;
        logic [2:0] kc;
        logic [4:0] frac;
        logic       relu;
    } t_mac_cfg;

    // tap row of a row*5+col index
    function automatic logic [2:0] tap_row(input logic [4:0] tap);
        logic [2:0] r;
        if (tap >= 5'd20)      r = 3'd4;
        else if (tap >= 5'd15) r = 3'd3;
        else if (tap >= 5'd10) r = 3'd2;
        else if (tap >= 5'd5)  r = 3'd1;
        else                   r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] tap_col(input logic [4:0] tap);
        logic [4:0] base;
        base = 5'(5) * {2'b00, tap_row(tap)};
        return 3'(tap - base);
    endfunction

endpackage

// File: rtl/dcv_ram.sv
`timescale 1ns / 1ps
// dcv_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module dcv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dcv_window.sv
`timescale 1ns / 1ps
// dcv_window: line history memory with forwarding and the kernel window registers
// depends on dcv_pkg, dcv_ram

module dcv_window #(
    parameter int MAX_KERNEL     = 5,
    parameter int MAX_LINE_WIDTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [$clog2(MAX_LINE_WIDTH+MAX_KERNEL-1)-1:0] i_rd_col,
    input  logic                   i_s1_pix,
    input  logic [dcv_pkg::DATA_W-1:0] i_s1_px,
    input  logic [$clog2(MAX_LINE_WIDTH+MAX_KERNEL-1)-1:0] i_s1_col,
    output logic [dcv_pkg::DATA_W-1:0] o_win [MAX_KERNEL][MAX_KERNEL]
);

    localparam int DW         = dcv_pkg::DATA_W;
    localparam int HIST       = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int HW         = DW * HIST;
    localparam int LINE_SLOTS = MAX_LINE_WIDTH + MAX_KERNEL - 1;
    localparam int LA_W       = $clog2(LINE_SLOTS);

    logic [HW-1:0]   ram_rdata;
    logic [HW-1:0]   old_hist;
    logic [HW-1:0]   n_hist;
    logic [DW-1:0]   colvec [MAX_KERNEL];
    logic            r_fwd_valid;
    logic [LA_W-1:0] r_fwd_addr;
    logic [HW-1:0]   r_fwd_data;
    logic [DW-1:0]   r_win [MAX_KERNEL][MAX_KERNEL];

    dcv_ram #(.WIDTH(HW), .DEPTH(LINE_SLOTS)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_en & i_s1_pix),
        .i_waddr (i_s1_col),
        .i_wdata (n_hist),
        .i_re    (i_en),
        .i_raddr (i_rd_col),
        .o_rdata (ram_rdata)
    );

    // the read was issued on the edge that wrote the same column
    assign old_hist = (r_fwd_valid && r_fwd_addr == i_s1_col) ? r_fwd_data : ram_rdata;

    always_comb begin
        for (int h = 0; h < HIST; h++) begin
            if (h == 0) n_hist[h*DW +: DW] = i_s1_px;
            else        n_hist[h*DW +: DW] = old_hist[(h-1)*DW +: DW];
        end
        for (int k = 0; k < MAX_KERNEL; k++) begin
            if (k == 0) colvec[k] = i_s1_px;
            else        colvec[k] = old_hist[(k-1)*DW +: DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_en) begin
            r_fwd_valid <= i_s1_pix;
        end
        if (i_en) begin
            r_fwd_addr <= i_s1_col;
            r_fwd_data <= n_hist;
        end
    end

    // window rows by age (0 is the current row), newest column at the top slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_KERNEL; k++) begin
                for (int s = 0; s < MAX_KERNEL; s++) begin
                    r_win[k][s] <= '0;
                end
            end
        end else if (i_en && i_s1_pix) begin
            for (int k = 0; k < MAX_KERNEL; k++) begin
                for (int s = 0; s < MAX_KERNEL - 1; s++) begin
                    r_win[k][s] <= r_win[k][s+1];
                end
                r_win[k][MAX_KERNEL-1] <= colvec[k];
            end
        end
    end

    assign o_win = r_win;

endmodule

// File: rtl/dcv_mac.sv
`timescale 1ns / 1ps
// dcv_mac: tap select, parallel multiply, shift, wrap-around sum, bias, relu, output register
// depends on dcv_pkg

module dcv_mac #(
    parameter int MAX_KERNEL = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  dcv_pkg::t_mac_cfg          i_cfg,
    input  logic                       i_valid,
    input  dcv_pkg::t_meta             i_meta,
    input  logic [dcv_pkg::DATA_W-1:0] i_win [MAX_KERNEL][MAX_KERNEL],
    input  logic [dcv_pkg::DATA_W-1:0] i_wt [MAX_KERNEL*MAX_KERNEL],
    input  logic [dcv_pkg::DATA_W-1:0] i_bias,
    output logic                       o_valid,
    output dcv_pkg::t_meta             o_meta,
    output logic [dcv_pkg::DATA_W-1:0] o_value
);

    localparam int DW   = dcv_pkg::DATA_W;
    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;

    // stage 2: window aligned, weights latched
    logic                 r_s2_valid;
    dcv_pkg::t_meta       r_s2_meta;
    logic [DW-1:0]        r_s2_wt [TAPS];
    logic [DW-1:0]        r_s2_bias;
    logic [DW-1:0]        px_tap [TAPS];
    logic signed [31:0]   prod [TAPS];
    // stage 3: products
    logic                 r_s3_valid;
    dcv_pkg::t_meta       r_s3_meta;
    logic signed [31:0]   r_s3_prod [TAPS];
    logic [DW-1:0]        r_s3_bias;
    logic [DW-1:0]        row_sum [MAX_KERNEL];
    // stage 4: row sums
    logic                 r_s4_valid;
    dcv_pkg::t_meta       r_s4_meta;
    logic [DW-1:0]        r_s4_row [MAX_KERNEL];
    logic [DW-1:0]        r_s4_bias;
    logic [DW-1:0]        total;
    // output register
    logic                 r_out_valid;
    dcv_pkg::t_meta       r_out_meta;
    logic [DW-1:0]        r_out_value;

    // tap (i,j) reads row age kr-1-i and slot MAX_KERNEL-kc+j
    always_comb begin
        for (int i = 0; i < MAX_KERNEL; i++) begin
            for (int j = 0; j < MAX_KERNEL; j++) begin
                px_tap[i*MAX_KERNEL+j] = '0;
                for (int k = 0; k < MAX_KERNEL; k++) begin
                    for (int s = 0; s < MAX_KERNEL; s++) begin
                        if (k == int'(i_cfg.kr) - 1 - i &&
                            s == MAX_KERNEL - int'(i_cfg.kc) + j) begin
                            px_tap[i*MAX_KERNEL+j] = i_win[k][s];
                        end
                    end
                end
                if (i < int'(i_cfg.kr) && j < int'(i_cfg.kc)) begin
                    prod[i*MAX_KERNEL+j] = $signed(px_tap[i*MAX_KERNEL+j]) *
                                           $signed(r_s2_wt[i*MAX_KERNEL+j]);
                end else begin
                    prod[i*MAX_KERNEL+j] = '0;
                end
            end
        end
    end

    // shifted and truncated terms, summed per kernel row
    always_comb begin
        logic signed [31:0] sh;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < MAX_KERNEL; j++) begin
                sh = r_s3_prod[i*MAX_KERNEL+j] >>> i_cfg.frac;
                row_sum[i] = row_sum[i] + sh[DW-1:0];
            end
        end
    end

    always_comb begin
        total = r_s4_bias;
        for (int i = 0; i < MAX_KERNEL; i++) begin
            total = total + r_s4_row[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid  <= i_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_meta  <= i_meta;
            r_s2_wt    <= i_wt;
            r_s2_bias  <= i_bias;
            r_s3_meta  <= r_s2_meta;
            r_s3_prod  <= prod;
            r_s3_bias  <= r_s2_bias;
            r_s4_meta  <= r_s3_meta;
            r_s4_row   <= row_sum;
            r_s4_bias  <= r_s3_bias;
            r_out_meta <= r_s4_meta;
            r_out_value <= (i_cfg.relu && total[DW-1]) ? '0 : total;
        end
    end

    assign o_valid = r_out_valid;
    assign o_meta  = r_out_meta;
    assign o_value = r_out_value;

endmodule

// File: rtl/depthwise_conv2d_fixed16.sv
`timescale 1ns / 1ps
// depthwise_conv2d_fixed16: top level, configuration, stream position, coefficient memories
// depends on dcv_pkg, dcv_ram, dcv_window, dcv_mac

// Stride-1 depthwise 2D convolution on int16. Weight (cmd 1) and bias (cmd 2)
// requests go into per-tap coefficient rams and a bias ram; pixel requests
// (cmd 0) stream pre-padded planes in raster order, one channel after another.
// One request is taken every clock cycle as long as the output side keeps up;
// the only stall is a result held in the output register while o_out_valid is
// high and i_out_ready is low, which freezes the whole pipeline for that cycle.
// An accepted pixel takes these steps on its way to o_out_valid: ram read on the
// accepting edge, then window shift, parallel multiply over all kernel taps,
// per-row sum, bias and relu into the output register. The line history lives
// in a single ram with one column per entry; a read that meets a write to the
// same column on the same edge takes the forwarded data. No clearing pass
// follows reset. Configuration writes belong in idle time and restart the
// stream at plane 0.

module depthwise_conv2d_fixed16 #(
    parameter int MAX_CHANNELS   = 64,
    parameter int MAX_KERNEL     = 5,
    parameter int MAX_LINE_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_channel,
    input  logic [4:0]  i_tap_index,
    input  logic signed [15:0] i_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_out_value,
    output logic [5:0]  o_out_channel,
    output logic [7:0]  o_out_row,
    output logic [7:0]  o_out_col,
    output logic        o_last
);

    localparam int DW         = dcv_pkg::DATA_W;
    localparam int ROW_W      = dcv_pkg::ROW_W;
    localparam int TAPS       = MAX_KERNEL * MAX_KERNEL;
    localparam int CH_LIMIT   = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
    localparam int OW_LIMIT   = (MAX_LINE_WIDTH < 256) ? MAX_LINE_WIDTH : 256;
    localparam int K_LIMIT    = (MAX_KERNEL < 7) ? MAX_KERNEL : 7;
    localparam int K_RESET    = (K_LIMIT < 3) ? K_LIMIT : 3;
    localparam int LINE_SLOTS = MAX_LINE_WIDTH + MAX_KERNEL - 1;
    localparam int COL_W      = $clog2(LINE_SLOTS + 1);
    localparam int LA_W       = $clog2(LINE_SLOTS);
    localparam int CH_AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration, stored already limited to the usable range
    logic [6:0] r_nch;
    logic [8:0] r_oh;
    logic [8:0] r_ow;
    logic [2:0] r_kr;
    logic [2:0] r_kc;
    logic       r_relu;
    logic [4:0] r_frac;

    // stream position
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [5:0]       r_plane;

    logic             en;
    logic             accept;
    logic             pix;
    logic             emit;
    logic [COL_W-1:0] in_w;
    logic [ROW_W-1:0] in_h;
    logic             col_end;
    logic             row_end;
    logic             plane_end;
    dcv_pkg::t_meta   meta;

    // stage 1: pixel waiting for its line history read
    logic             r_s1_pix;
    logic             r_s1_emit;
    logic [DW-1:0]    r_s1_px;
    logic [LA_W-1:0]  r_s1_col;
    dcv_pkg::t_meta   r_s1_meta;

    logic [DW-1:0]    win [MAX_KERNEL][MAX_KERNEL];
    logic [DW-1:0]    wt_rdata [TAPS];
    logic [DW-1:0]    bias_rdata;
    logic [2:0]       ld_row;
    logic [2:0]       ld_col;
    logic             wt_ok;
    logic             bias_ok;
    dcv_pkg::t_mac_cfg mac_cfg;
    dcv_pkg::t_meta   out_meta;
    logic [DW-1:0]    out_value;

    // the pipeline moves whenever the output register is free or being drained
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;
    assign pix        = accept && (i_cmd == dcv_pkg::CMD_PIXEL);

    assign in_w = COL_W'(r_ow) + COL_W'(r_kc) - COL_W'(1);
    assign in_h = ROW_W'(r_oh) + ROW_W'(r_kr) - ROW_W'(1);

    assign col_end   = (r_col == in_w - COL_W'(1));
    assign row_end   = (r_row == in_h - ROW_W'(1));
    assign plane_end = (r_plane == 6'(r_nch - 7'd1));

    // a full window sits behind this pixel once kr-1 rows and kc-1 columns passed
    assign emit = (r_row >= ROW_W'(r_kr) - ROW_W'(1)) &&
                  (r_col >= COL_W'(r_kc) - COL_W'(1));

    always_comb begin
        meta.channel = r_plane;
        meta.row     = 8'(r_row - (ROW_W'(r_kr) - ROW_W'(1)));
        meta.col     = 8'(r_col - (COL_W'(r_kc) - COL_W'(1)));
        meta.last    = plane_end && row_end && col_end;
    end

    // configuration writes, also restart the stream position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch   <= 7'd1;
            r_oh    <= 9'd1;
            r_ow    <= 9'd1;
            r_kr    <= 3'(K_RESET);
            r_kc    <= 3'(K_RESET);
            r_relu  <= 1'b0;
            r_frac  <= 5'd0;
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else if (i_cfg_we) begin
            case (dcv_pkg::t_cfg_idx'(i_cfg_index))
                dcv_pkg::CFG_CHANNELS: begin
                    if (i_cfg_data[6:0] == 7'd0)               r_nch <= 7'd1;
                    else if (int'(i_cfg_data[6:0]) > CH_LIMIT) r_nch <= 7'(CH_LIMIT);
                    else                                       r_nch <= i_cfg_data[6:0];
                end
                dcv_pkg::CFG_OUT_HEIGHT: begin
                    if (i_cfg_data == 9'd0)        r_oh <= 9'd1;
                    else if (i_cfg_data > 9'd256)  r_oh <= 9'd256;
                    else                           r_oh <= i_cfg_data;
                end
                dcv_pkg::CFG_OUT_WIDTH: begin
                    if (i_cfg_data == 9'd0)              r_ow <= 9'd1;
                    else if (int'(i_cfg_data) > OW_LIMIT) r_ow <= 9'(OW_LIMIT);
                    else                                 r_ow <= i_cfg_data;
                end
                dcv_pkg::CFG_KER_ROWS: begin
                    if (i_cfg_data[2:0] == 3'd0)              r_kr <= 3'd1;
                    else if (int'(i_cfg_data[2:0]) > K_LIMIT) r_kr <= 3'(K_LIMIT);
                    else                                      r_kr <= i_cfg_data[2:0];
                end
                dcv_pkg::CFG_KER_COLS: begin
                    if (i_cfg_data[2:0] == 3'd0)              r_kc <= 3'd1;
                    else if (int'(i_cfg_data[2:0]) > K_LIMIT) r_kc <= 3'(K_LIMIT);
                    else                                      r_kc <= i_cfg_data[2:0];
                end
                dcv_pkg::CFG_RELU: begin
                    r_relu <= i_cfg_data[0];
                end
                dcv_pkg::CFG_FRAC: begin
                    r_frac <= i_cfg_data[4:0];
                end
                default: begin
                end
            endcase
            if (i_cfg_index <= dcv_pkg::CFG_FRAC) begin
                r_col   <= '0;
                r_row   <= '0;
                r_plane <= '0;
            end
        end else if (pix) begin
            // raster advance, plane wraps back to 0 after the last one
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row   <= '0;
                    r_plane <= plane_end ? 6'd0 : r_plane + 6'd1;
                end else begin
                    r_row <= r_row + ROW_W'(1);
                end
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pix  <= 1'b0;
            r_s1_emit <= 1'b0;
        end else if (en) begin
            r_s1_pix  <= pix;
            r_s1_emit <= pix && emit;
        end
        if (en) begin
            r_s1_px   <= i_value;
            r_s1_col  <= LA_W'(r_col);
            r_s1_meta <= meta;
        end
    end

    // coefficient loads, addresses outside the store are dropped
    assign ld_row  = dcv_pkg::tap_row(i_tap_index);
    assign ld_col  = dcv_pkg::tap_col(i_tap_index);
    assign wt_ok   = accept && (i_cmd == dcv_pkg::CMD_WEIGHT) &&
                     (int'(i_channel) < MAX_CHANNELS) && (i_tap_index <= 5'd24) &&
                     (int'(ld_row) < MAX_KERNEL) && (int'(ld_col) < MAX_KERNEL);
    assign bias_ok = accept && (i_cmd == dcv_pkg::CMD_BIAS) &&
                     (int'(i_channel) < MAX_CHANNELS);

    // one ram per tap so every weight of the plane is read in parallel
    for (genvar gi = 0; gi < MAX_KERNEL; gi++) begin : g_wrow
        for (genvar gj = 0; gj < MAX_KERNEL; gj++) begin : g_wcol
            dcv_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_wt_ram (
                .i_clk   (i_clk),
                .i_we    (wt_ok && int'(ld_row) == gi && int'(ld_col) == gj),
                .i_waddr (CH_AW'(i_channel)),
                .i_wdata (i_value),
                .i_re    (en),
                .i_raddr (CH_AW'(r_plane)),
                .o_rdata (wt_rdata[gi*MAX_KERNEL+gj])
            );
        end
    end

    dcv_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (bias_ok),
        .i_waddr (CH_AW'(i_channel)),
        .i_wdata (i_value),
        .i_re    (en),
        .i_raddr (CH_AW'(r_plane)),
        .o_rdata (bias_rdata)
    );

    dcv_window #(.MAX_KERNEL(MAX_KERNEL), .MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_rd_col (LA_W'(r_col)),
        .i_s1_pix (r_s1_pix),
        .i_s1_px  (r_s1_px),
        .i_s1_col (r_s1_col),
        .o_win    (win)
    );

    always_comb begin
        mac_cfg.kr   = r_kr;
        mac_cfg.kc   = r_kc;
        mac_cfg.frac = r_frac;
        mac_cfg.relu = r_relu;
    end

    dcv_mac #(.MAX_KERNEL(MAX_KERNEL)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (mac_cfg),
        .i_valid (r_s1_emit),
        .i_meta  (r_s1_meta),
        .i_win   (win),
        .i_wt    (wt_rdata),
        .i_bias  (bias_rdata),
        .o_valid (o_out_valid),
        .o_meta  (out_meta),
        .o_value (out_value)
    );

    assign o_out_value   = out_value;
    assign o_out_channel = out_meta.channel;
    assign o_out_row     = out_meta.row;
    assign o_out_col     = out_meta.col;
    assign o_last        = out_meta.last;

endmodule

// File: rtl/dcv_checker.sv
`timescale 1ns / 1ps
// dcv_checker: port level assertions for the depthwise convolution top level
// depends on depthwise_conv2d_fixed16 (bound to it)

module dcv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_value,
    input logic [5:0]  o_out_channel,
    input logic [7:0]  o_out_row,
    input logic [7:0]  o_out_col,
    input logic        o_last
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a held result keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("stalled result dropped");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_value) && $stable(o_out_channel) &&
            $stable(o_out_row) && $stable(o_out_col) && $stable(o_last))
        else $error("stalled result changed");

    // a blocked output freezes the pipeline, so no request is taken
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while pipeline is stalled");

endmodule

bind depthwise_conv2d_fixed16 dcv_checker u_dcv_checker (.*);
